[hw/rtl/abpa_pkg.sv]
package abpa_pkg;

    // Field widths of the request and result ports
    localparam int TYPE_W   = 1;
    localparam int TOTAL_W  = 9;
    localparam int BLOCKS_W = 7;
    localparam int BNUM_W   = 7;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;
    localparam int HADDR_W  = 8;
    localparam int SPAN_W   = 9;

    // Largest number of addresses one allocate request may claim
    localparam int MAX_RESULTS = 64;

    // Request type codes
    localparam logic [TYPE_W-1:0] REQ_PARTITION = 1'b0;
    localparam logic [TYPE_W-1:0] REQ_ALLOC     = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_COUNT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_BLOCK  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_SHORT      = 2'd3;

    // Kind of single-result reply the controller asks the datapath to send
    typedef enum logic [2:0] {
        RES_SETUP,
        RES_BAD_COUNT,
        RES_BAD_BLOCK,
        RES_SHORT,
        RES_EMPTY
    } t_res_kind;

    // Controller to datapath commands
    typedef struct packed {
        logic      load;
        logic      sweep_start;
        logic      sweep_fc;
        logic      div_start;
        logic      set_geom;
        logic      alloc_prep;
        logic      scan_init;
        logic      scan_run;
        logic      emit;
        t_res_kind kind;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic is_setup;
        logic cnt_bad;
        logic bnum_bad;
        logic short_req;
        logic zero_req;
        logic div_done;
        logic sweep_done;
        logic sweeping;
        logic scan_done;
        logic claim;
        logic out_free;
    } t_dp_stat;

endpackage

[hw/rtl/abpa_div.sv]
module abpa_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [abpa_pkg::TOTAL_W-1:0]   i_dividend,
    input  logic [abpa_pkg::BLOCKS_W-1:0]  i_divisor,
    output logic                           o_done,
    output logic [abpa_pkg::TOTAL_W-1:0]   o_quot
);

    localparam int QW = abpa_pkg::TOTAL_W;
    localparam int DW = abpa_pkg::BLOCKS_W;
    localparam int CW = $clog2(QW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_div;
    logic [QW-1:0] r_q;

    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    // One restoring step: bring down the next dividend bit and try a subtract
    always_comb begin
        trial = {r_rem, r_q[QW-1]};
        ge    = trial >= {1'b0, r_div};
        diff  = trial - {1'b0, r_div};
    end

    // Control: busy flag, step counter, done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(QW - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_q   <= i_dividend;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
            r_q   <= {r_q[QW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

[hw/rtl/abpa_ctrl.sv]
module abpa_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  abpa_pkg::t_dp_stat i_stat,
    output abpa_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_INIT,
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_DIV,
        S_SWEEP,
        S_CHECK,
        S_SCAN,
        S_RESULT
    } t_state;

    t_state              r_state;
    abpa_pkg::t_res_kind r_kind;

    // State register and the pending reply kind
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_kind  <= abpa_pkg::RES_SETUP;
        end else begin
            unique case (r_state)
                S_INIT: begin
                    r_state <= S_CLEAR;
                end
                S_CLEAR: begin
                    if (i_stat.sweep_done) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_in_valid) r_state <= S_DECODE;
                end
                S_DECODE: begin
                    if (i_stat.is_setup) begin
                        if (i_stat.cnt_bad) begin
                            r_kind  <= abpa_pkg::RES_BAD_COUNT;
                            r_state <= S_RESULT;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end else if (i_stat.bnum_bad) begin
                        r_kind  <= abpa_pkg::RES_BAD_BLOCK;
                        r_state <= S_RESULT;
                    end else begin
                        r_state <= S_CHECK;
                    end
                end
                S_DIV: begin
                    if (i_stat.div_done) r_state <= S_SWEEP;
                end
                S_SWEEP: begin
                    if (i_stat.sweep_done) begin
                        r_kind  <= abpa_pkg::RES_SETUP;
                        r_state <= S_RESULT;
                    end
                end
                S_CHECK: begin
                    if (i_stat.short_req) begin
                        r_kind  <= abpa_pkg::RES_SHORT;
                        r_state <= S_RESULT;
                    end else if (i_stat.zero_req) begin
                        r_kind  <= abpa_pkg::RES_EMPTY;
                        r_state <= S_RESULT;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (i_stat.scan_done) r_state <= S_IDLE;
                end
                S_RESULT: begin
                    if (i_stat.out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_INIT;
            endcase
        end
    end

    // Command decode
    always_comb begin
        o_cmd = '0;
        o_cmd.kind = r_kind;
        unique case (r_state)
            S_INIT:   o_cmd.sweep_start = 1'b1;
            S_IDLE:   o_cmd.load = i_in_valid;
            S_DECODE: begin
                o_cmd.div_start  = i_stat.is_setup && !i_stat.cnt_bad;
                o_cmd.alloc_prep = !i_stat.is_setup && !i_stat.bnum_bad;
            end
            S_DIV: begin
                o_cmd.set_geom    = i_stat.div_done;
                o_cmd.sweep_start = i_stat.div_done;
                o_cmd.sweep_fc    = i_stat.div_done;
            end
            S_CHECK:  o_cmd.scan_init = 1'b1;
            S_SCAN:   o_cmd.scan_run = 1'b1;
            S_RESULT: o_cmd.emit = i_stat.out_free;
            default:  o_cmd.kind = r_kind;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

[hw/rtl/abpa_dp.sv]
module abpa_dp #(
    parameter int BLOCK_LIMIT = 64,
    parameter int POOL_SIZE   = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  abpa_pkg::t_dp_cmd               i_cmd,
    output abpa_pkg::t_dp_stat              o_stat,
    input  logic [abpa_pkg::TYPE_W-1:0]     i_req_type,
    input  logic [abpa_pkg::TOTAL_W-1:0]    i_total_wanted,
    input  logic [abpa_pkg::BLOCKS_W-1:0]   i_blocks_wanted,
    input  logic [abpa_pkg::BNUM_W-1:0]     i_block_number,
    input  logic [abpa_pkg::COUNT_W-1:0]    i_request_count,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [abpa_pkg::STATUS_W-1:0]   o_status,
    output logic                            o_has_address,
    output logic [abpa_pkg::HADDR_W-1:0]    o_host_address,
    output logic [abpa_pkg::SPAN_W-1:0]     o_span,
    output logic                            o_last
);

    localparam int SW        = abpa_pkg::SPAN_W;
    localparam int AW        = $clog2(POOL_SIZE);
    localparam int BIW       = (BLOCK_LIMIT > 1) ? $clog2(BLOCK_LIMIT) : 1;
    localparam int SWEEP_LEN = (POOL_SIZE > BLOCK_LIMIT) ? POOL_SIZE : BLOCK_LIMIT;
    localparam int KW        = (SWEEP_LEN > 1) ? $clog2(SWEEP_LEN) : 1;

    // Captured request fields
    logic [abpa_pkg::TYPE_W-1:0]   r_type;
    logic [abpa_pkg::TOTAL_W-1:0]  r_total;
    logic [abpa_pkg::BLOCKS_W-1:0] r_blk;
    logic [abpa_pkg::BNUM_W-1:0]   r_bnum;
    logic [abpa_pkg::COUNT_W-1:0]  r_want;

    // Pool geometry
    logic [abpa_pkg::BLOCKS_W-1:0] r_active;
    logic [SW-1:0]                 r_span;

    // Storage
    logic [SW-1:0] fc_mem [BLOCK_LIMIT];
    logic          map_mem [POOL_SIZE];
    logic [SW-1:0] r_fc_q;
    logic          r_map_q;

    // Sweep (map clear and free count fill)
    logic          r_sweeping;
    logic          r_sweep_fc;
    logic [KW-1:0] r_k;
    logic [SW:0]   r_s;

    // Allocation scan
    logic [SW+7:0]               r_start;
    logic [AW-1:0]               r_ptr;
    logic [AW-1:0]               r_b_addr;
    logic                        r_b_vld;
    logic [SW-1:0]               r_free;
    logic [abpa_pkg::COUNT_W-1:0] r_n;
    logic [BIW-1:0]              r_idx;

    // Output register
    logic                          r_out_vld;
    logic [abpa_pkg::STATUS_W-1:0] r_o_status;
    logic                          r_o_has;
    logic [abpa_pkg::HADDR_W-1:0]  r_o_addr;
    logic [SW-1:0]                 r_o_span;
    logic                          r_o_last;

    logic          out_free;
    logic [7:0]    idx8;
    logic [SW-1:0] tot_c;
    logic [SW-1:0] cap;
    logic          div_done;
    logic [SW-1:0] quot;
    logic          s_ok;
    logic [SW:0]   s_rem;
    logic [SW-1:0] sweep_val;
    logic          sweep_last;
    logic          sweep_map_we;
    logic          sweep_fc_we;
    logic          stall;
    logic          adv;
    logic          claim;
    logic          claim_last;
    logic [SW-1:0] free_dec;

    assign out_free = !r_out_vld || i_out_ready;
    assign idx8     = {1'b0, r_bnum} - 8'd1;

    // Request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_type  <= i_req_type;
            r_total <= i_total_wanted;
            r_blk   <= i_blocks_wanted;
            r_bnum  <= i_block_number;
            r_want  <= i_request_count;
        end
    end

    // Total clipped to the pool, then rounded up to a power of two
    always_comb begin
        tot_c = (r_total > SW'(POOL_SIZE)) ? SW'(POOL_SIZE) : r_total;
        cap   = SW'(1);
        for (int b = 0; b < SW - 1; b++) begin
            if (tot_c > (SW'(1) << b)) cap = SW'(1) << (b + 1);
        end
    end

    abpa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (cap),
        .i_divisor  (r_blk),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    // Block size and block count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
            r_span   <= SW'(1);
        end else if (i_cmd.set_geom) begin
            r_active <= r_blk;
            r_span   <= (quot == '0) ? SW'(1) : quot;
        end
    end

    // Free count of the block starting at r_s: clipped at the pool end
    always_comb begin
        s_ok       = r_s < (SW + 1)'(POOL_SIZE);
        s_rem      = (SW + 1)'(POOL_SIZE) - r_s;
        sweep_val  = '0;
        if (s_ok) sweep_val = ({1'b0, r_span} < s_rem) ? r_span : s_rem[SW-1:0];
        sweep_last = r_sweeping && (r_k == KW'(SWEEP_LEN - 1));
        sweep_map_we = r_sweeping && ((SW + 1)'(r_k) < (SW + 1)'(POOL_SIZE));
        sweep_fc_we  = r_sweeping && r_sweep_fc && ((SW + 1)'(r_k) < (SW + 1)'(r_blk));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweeping <= 1'b0;
        end else if (i_cmd.sweep_start) begin
            r_sweeping <= 1'b1;
        end else if (sweep_last) begin
            r_sweeping <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep_start) begin
            r_sweep_fc <= i_cmd.sweep_fc;
            r_k        <= '0;
            r_s        <= '0;
        end else if (r_sweeping) begin
            r_k <= r_k + 1'b1;
            if (s_ok) r_s <= r_s + {1'b0, r_span};
        end
    end

    // Scan pipeline: read stage at r_ptr, check stage at r_b_addr
    always_comb begin
        stall      = r_b_vld && !r_map_q && !out_free;
        adv        = i_cmd.scan_run && !stall;
        claim      = i_cmd.scan_run && r_b_vld && !r_map_q && out_free;
        claim_last = claim && (r_n == r_want - 1'b1);
        free_dec   = r_free - 1'b1;
    end

    // Allocation setup: start address and block index
    always_ff @(posedge i_clk) begin
        if (i_cmd.alloc_prep) begin
            r_start <= idx8 * r_span;
            r_idx   <= idx8[BIW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (i_cmd.scan_init) begin
            r_b_vld <= 1'b0;
        end else if (adv) begin
            r_b_vld <= !claim_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_ptr  <= r_start[AW-1:0];
            r_free <= r_fc_q;
            r_n    <= '0;
        end else begin
            if (adv) begin
                r_b_addr <= r_ptr;
                r_ptr    <= r_ptr + 1'b1;
            end
            if (claim) begin
                r_free <= free_dec;
                r_n    <= r_n + 1'b1;
            end
        end
    end

    // Used-address map
    always_ff @(posedge i_clk) begin
        if (sweep_map_we) begin
            map_mem[r_k[AW-1:0]] <= 1'b0;
        end else if (claim) begin
            map_mem[r_b_addr] <= 1'b1;
        end
        if (adv) r_map_q <= map_mem[r_ptr];
    end

    // Per-block free counts
    always_ff @(posedge i_clk) begin
        if (sweep_fc_we) begin
            fc_mem[r_k[BIW-1:0]] <= sweep_val;
        end else if (claim_last) begin
            fc_mem[r_idx] <= free_dec;
        end
        if (i_cmd.alloc_prep) r_fc_q <= fc_mem[idx8[BIW-1:0]];
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (claim || i_cmd.emit) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (claim) begin
            r_o_status <= abpa_pkg::ST_OK;
            r_o_has    <= 1'b1;
            r_o_addr   <= abpa_pkg::HADDR_W'(r_b_addr);
            r_o_span   <= free_dec;
            r_o_last   <= claim_last;
        end else if (i_cmd.emit) begin
            r_o_has  <= 1'b0;
            r_o_addr <= '0;
            r_o_last <= 1'b1;
            unique case (i_cmd.kind)
                abpa_pkg::RES_SETUP: begin
                    r_o_status <= abpa_pkg::ST_OK;
                    r_o_span   <= r_span;
                end
                abpa_pkg::RES_BAD_COUNT: begin
                    r_o_status <= abpa_pkg::ST_BAD_COUNT;
                    r_o_span   <= '0;
                end
                abpa_pkg::RES_BAD_BLOCK: begin
                    r_o_status <= abpa_pkg::ST_BAD_BLOCK;
                    r_o_span   <= '0;
                end
                abpa_pkg::RES_SHORT: begin
                    r_o_status <= abpa_pkg::ST_SHORT;
                    r_o_span   <= r_free;
                end
                abpa_pkg::RES_EMPTY: begin
                    r_o_status <= abpa_pkg::ST_OK;
                    r_o_span   <= r_free;
                end
                default: begin
                    r_o_status <= abpa_pkg::ST_OK;
                    r_o_span   <= '0;
                end
            endcase
        end
    end

    // Status to the controller
    always_comb begin
        o_stat.is_setup   = (r_type == abpa_pkg::REQ_PARTITION);
        o_stat.cnt_bad    = (r_blk == '0) || ((SW + 1)'(r_blk) > (SW + 1)'(BLOCK_LIMIT));
        o_stat.bnum_bad   = (r_bnum == '0) || (r_bnum > r_active);
        o_stat.short_req  = (SW'(r_want) > r_fc_q)
                         || (r_want > abpa_pkg::COUNT_W'(abpa_pkg::MAX_RESULTS));
        o_stat.zero_req   = (r_want == '0);
        o_stat.div_done   = div_done;
        o_stat.sweep_done = sweep_last;
        o_stat.sweeping   = r_sweeping;
        o_stat.scan_done  = claim_last;
        o_stat.claim      = claim;
        o_stat.out_free   = out_free;
    end

    assign o_out_valid    = r_out_vld;
    assign o_status       = r_o_status;
    assign o_has_address  = r_o_has;
    assign o_host_address = r_o_addr;
    assign o_span         = r_o_span;
    assign o_last         = r_o_last;

endmodule

[hw/rtl/address_block_pool_allocator.sv]
// Address block pool allocator. Keeps a pool of POOL_SIZE host addresses split
// into up to BLOCK_LIMIT equal blocks. A setup request (req_type 0) rounds
// total_wanted up to a power of two, divides it by blocks_wanted in a 9-step
// serial divider, then sweeps max(POOL_SIZE, BLOCK_LIMIT) entries one per
// cycle to clear the used-address map and load each block's free count; its
// one result is loaded into the output register after the sweep, and the next
// request is taken once it is there.
// An allocate request (req_type 1) reads one map entry per cycle, from the
// block start up to the last address claimed, while no claim waits for the
// output register; it returns one result per claimed address, or one
// status result. A map-clearing sweep also runs once after reset, and no request
// is taken until it ends. One request is in work at a time; a finished result
// waits in the output register while the next request is taken. o_last marks
// the final result of each request.
module address_block_pool_allocator #(
    parameter int BLOCK_LIMIT = 64,
    parameter int POOL_SIZE   = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [abpa_pkg::TYPE_W-1:0]     i_req_type,
    input  logic [abpa_pkg::TOTAL_W-1:0]    i_total_wanted,
    input  logic [abpa_pkg::BLOCKS_W-1:0]   i_blocks_wanted,
    input  logic [abpa_pkg::BNUM_W-1:0]     i_block_number,
    input  logic [abpa_pkg::COUNT_W-1:0]    i_request_count,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [abpa_pkg::STATUS_W-1:0]   o_status,
    output logic                            o_has_address,
    output logic [abpa_pkg::HADDR_W-1:0]    o_host_address,
    output logic [abpa_pkg::SPAN_W-1:0]     o_span,
    output logic                            o_last
);

    abpa_pkg::t_dp_cmd  dp_cmd;
    abpa_pkg::t_dp_stat dp_stat;

    abpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    abpa_dp #(
        .BLOCK_LIMIT (BLOCK_LIMIT),
        .POOL_SIZE   (POOL_SIZE)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .i_req_type      (i_req_type),
        .i_total_wanted  (i_total_wanted),
        .i_blocks_wanted (i_blocks_wanted),
        .i_block_number  (i_block_number),
        .i_request_count (i_request_count),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_has_address   (o_has_address),
        .o_host_address  (o_host_address),
        .o_span          (o_span),
        .o_last          (o_last)
    );

    // No new request while the map is being swept
    a_no_accept_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !dp_stat.sweeping)
        else $error("request port open during sweep");

    // A result is only loaded when the output register can take it
    a_push_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dp_cmd.emit || dp_stat.claim) |-> dp_stat.out_free)
        else $error("result loaded over a pending transfer");

    // Claims and single replies never collide
    a_one_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(dp_cmd.emit && dp_stat.claim))
        else $error("two result sources in one cycle");

    // The port stays closed right after reset for the clearing sweep
    a_closed_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("request port open right after reset");

endmodule

[dv/address_block_pool_allocator_test.sv]
`timescale 1ns / 1ps

module address_block_pool_allocator_test;

    localparam int POOL_SIZE      = 256;
    localparam int BLOCK_LIMIT    = 64;
    localparam int RESET_CYCLES   = 10;
    localparam int RANDOM_ITEMS   = 300;
    localparam int QUIET_TAIL     = 40;
    localparam int PRESSURE_AT    = 200;
    localparam int PRESSURE_HOLD  = 400;
    localparam int DRAIN_CYCLES   = 600;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct packed {
        logic [abpa_pkg::TYPE_W-1:0]   req_type;
        logic [abpa_pkg::TOTAL_W-1:0]  total_wanted;
        logic [abpa_pkg::BLOCKS_W-1:0] blocks_wanted;
        logic [abpa_pkg::BNUM_W-1:0]   block_number;
        logic [abpa_pkg::COUNT_W-1:0]  request_count;
    } t_pool_req;

    typedef struct packed {
        logic [abpa_pkg::STATUS_W-1:0] status;
        logic                          has_address;
        logic [abpa_pkg::HADDR_W-1:0]  host_address;
        logic [abpa_pkg::SPAN_W-1:0]   span;
        logic                          last;
    } t_pool_result;

    // DUT ports
    logic                          i_clk           = 1'b0;
    logic                          i_rst_n         = 1'b0;
    logic                          i_in_valid      = 1'b0;
    logic                          o_in_ready;
    logic [abpa_pkg::TYPE_W-1:0]   i_req_type      = '0;
    logic [abpa_pkg::TOTAL_W-1:0]  i_total_wanted  = '0;
    logic [abpa_pkg::BLOCKS_W-1:0] i_blocks_wanted = '0;
    logic [abpa_pkg::BNUM_W-1:0]   i_block_number  = '0;
    logic [abpa_pkg::COUNT_W-1:0]  i_request_count = '0;
    logic                          o_out_valid;
    logic                          i_out_ready     = 1'b0;
    logic [abpa_pkg::STATUS_W-1:0] o_status;
    logic                          o_has_address;
    logic [abpa_pkg::HADDR_W-1:0]  o_host_address;
    logic [abpa_pkg::SPAN_W-1:0]   o_span;
    logic                          o_last;

    // Stimulus and expected results
    t_pool_req    pending_q[$];
    t_pool_result claims_q[$];

    // Predicted pool state
    int pool_blocks = 0;
    int pool_span   = 1;
    int pool_free[BLOCK_LIMIT];
    bit pool_used[POOL_SIZE];

    // Generator's view of the pool, used only to steer stimulus
    int gen_blocks = 0;
    int gen_free[BLOCK_LIMIT];

    // Handshake bookkeeping and counters
    bit in_took       = 1'b0;
    int send_gap      = 0;
    int hold_left     = 0;
    bit pressure_done = 1'b0;
    int results_seen  = 0;
    int idle_cycles   = 0;
    int fail_count    = 0;
    int setups_seen   = 0;
    int allocs_seen   = 0;
    int addrs_claimed = 0;
    int refusals      = 0;

    address_block_pool_allocator #(
        .BLOCK_LIMIT (BLOCK_LIMIT),
        .POOL_SIZE   (POOL_SIZE)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_req_type      (i_req_type),
        .i_total_wanted  (i_total_wanted),
        .i_blocks_wanted (i_blocks_wanted),
        .i_block_number  (i_block_number),
        .i_request_count (i_request_count),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_has_address   (o_has_address),
        .o_host_address  (o_host_address),
        .o_span          (o_span),
        .o_last          (o_last)
    );

    always #1 i_clk = ~i_clk;

    // Block size after setup: clipped total rounded up to a power of two, over blocks, at least 1
    function automatic int rounded_span(input int total, input int blocks);
        int tot;
        int cap;
        int sz;
        tot = (total > POOL_SIZE) ? POOL_SIZE : total;
        cap = 1;
        while (cap < tot) cap = cap * 2;
        sz = cap / blocks;
        if (sz == 0) sz = 1;
        return sz;
    endfunction

    // Addresses in zero-based block idx, end clipped to the pool
    function automatic int block_capacity(input int span, input int idx);
        int s;
        int e;
        s = idx * span;
        e = s + span - 1;
        if (e > POOL_SIZE - 1) e = POOL_SIZE - 1;
        return (s <= e) ? (e - s + 1) : 0;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        fail_count++;
    endtask

    function automatic t_pool_result make_result(input logic [abpa_pkg::STATUS_W-1:0] st,
                                                 input bit has, input int addr,
                                                 input int span, input bit lst);
        t_pool_result r;
        r.status       = st;
        r.has_address  = has;
        r.host_address = addr[abpa_pkg::HADDR_W-1:0];
        r.span         = span[abpa_pkg::SPAN_W-1:0];
        r.last         = lst;
        return r;
    endfunction

    // Work out every result one accepted request causes
    task automatic predict_request(input t_pool_req req);
        int           blocks;
        int           bnum;
        int           want;
        int           idx;
        int           start;
        int           cnt;
        int           a;
        int           n;
        t_pool_result held;
        if (req.req_type == abpa_pkg::REQ_PARTITION) begin
            setups_seen++;
            blocks = req.blocks_wanted;
            if (blocks == 0 || blocks > BLOCK_LIMIT) begin
                claims_q.push_back(make_result(abpa_pkg::ST_BAD_COUNT, 0, 0, 0, 1));
                refusals++;
            end else begin
                pool_span   = rounded_span(req.total_wanted, blocks);
                pool_blocks = blocks;
                for (idx = 0; idx < blocks; idx++) pool_free[idx] = block_capacity(pool_span, idx);
                for (a = 0; a < POOL_SIZE; a++) pool_used[a] = 1'b0;
                claims_q.push_back(make_result(abpa_pkg::ST_OK, 0, 0, pool_span, 1));
            end
        end else begin
            allocs_seen++;
            bnum = req.block_number;
            want = req.request_count;
            if (bnum < 1 || bnum > pool_blocks || bnum > BLOCK_LIMIT) begin
                claims_q.push_back(make_result(abpa_pkg::ST_BAD_BLOCK, 0, 0, 0, 1));
                refusals++;
            end else begin
                idx = bnum - 1;
                if (pool_free[idx] < want || want > abpa_pkg::MAX_RESULTS) begin
                    claims_q.push_back(make_result(abpa_pkg::ST_SHORT, 0, 0, pool_free[idx], 1));
                    refusals++;
                end else begin
                    // Scan from block start, claim first free addresses
                    start = idx * pool_span;
                    cnt   = block_capacity(pool_span, idx);
                    n     = 0;
                    for (a = start; a < start + cnt && a < POOL_SIZE && n < want; a++) begin
                        if (!pool_used[a]) begin
                            pool_used[a] = 1'b1;
                            if (pool_free[idx] > 0) pool_free[idx]--;
                            if (n > 0) claims_q.push_back(held);
                            held = make_result(abpa_pkg::ST_OK, 1, a, pool_free[idx], 0);
                            n++;
                        end
                    end
                    if (n == 0) begin
                        claims_q.push_back(make_result(abpa_pkg::ST_OK, 0, 0, pool_free[idx], 1));
                    end else begin
                        held.last = 1'b1;
                        claims_q.push_back(held);
                    end
                end
            end
        end
    endtask

    // Queue one request and keep the generator's view of the pool in step
    task automatic queue_request(input logic [abpa_pkg::TYPE_W-1:0] t, input int total,
                                 input int blocks, input int bnum, input int count);
        t_pool_req r;
        int        i;
        int        sz;
        r.req_type      = t;
        r.total_wanted  = total[abpa_pkg::TOTAL_W-1:0];
        r.blocks_wanted = blocks[abpa_pkg::BLOCKS_W-1:0];
        r.block_number  = bnum[abpa_pkg::BNUM_W-1:0];
        r.request_count = count[abpa_pkg::COUNT_W-1:0];
        pending_q.push_back(r);
        if (t == abpa_pkg::REQ_PARTITION) begin
            if (r.blocks_wanted >= 1 && r.blocks_wanted <= BLOCK_LIMIT) begin
                gen_blocks = r.blocks_wanted;
                sz = rounded_span(r.total_wanted, gen_blocks);
                for (i = 0; i < gen_blocks; i++) gen_free[i] = block_capacity(sz, i);
            end
        end else if (r.block_number >= 1 && r.block_number <= gen_blocks) begin
            if (r.request_count <= gen_free[r.block_number-1]
                && r.request_count <= abpa_pkg::MAX_RESULTS)
                gen_free[r.block_number-1] -= r.request_count;
        end
    endtask

    // Request driver: one request per transfer, random gaps until the tail
    always @(negedge i_clk) begin
        t_pool_req nxt;
        logic      keep;
        if (i_rst_n) begin
            keep = i_in_valid && !in_took;
            if (!keep) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_q.size() > 0) begin
                    if (pending_q.size() > QUIET_TAIL && $urandom_range(0, 99) < 15) begin
                        send_gap = $urandom_range(1, 10) - 1;
                    end else begin
                        nxt = pending_q.pop_front();
                        i_req_type      <= nxt.req_type;
                        i_total_wanted  <= nxt.total_wanted;
                        i_blocks_wanted <= nxt.blocks_wanted;
                        i_block_number  <= nxt.block_number;
                        i_request_count <= nxt.request_count;
                        keep = 1'b1;
                    end
                end
            end
            i_in_valid <= keep;
        end
    end

    // Result receiver: random hold-off bursts plus one long hold-off
    always @(negedge i_clk) begin
        logic rdy;
        rdy = 1'b1;
        if (i_rst_n) begin
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (!pressure_done && results_seen >= PRESSURE_AT) begin
                pressure_done = 1'b1;
                hold_left     = PRESSURE_HOLD - 1;
                rdy           = 1'b0;
            end else if (pending_q.size() > QUIET_TAIL && $urandom_range(0, 99) < 12) begin
                hold_left = $urandom_range(1, 10) - 1;
                rdy       = 1'b0;
            end
        end
        i_out_ready <= rdy;
    end

    // Monitor: predict on request transfer, check on result transfer
    always @(posedge i_clk) begin
        t_pool_result got;
        t_pool_result want;
        t_pool_req    req;
        if (!i_rst_n) begin
            in_took = 1'b0;
        end else begin
            in_took = i_in_valid && o_in_ready;
            if (in_took) begin
                req.req_type      = i_req_type;
                req.total_wanted  = i_total_wanted;
                req.blocks_wanted = i_blocks_wanted;
                req.block_number  = i_block_number;
                req.request_count = i_request_count;
                predict_request(req);
            end
            if (o_out_valid && i_out_ready) begin
                got.status       = o_status;
                got.has_address  = o_has_address;
                got.host_address = o_host_address;
                got.span         = o_span;
                got.last         = o_last;
                results_seen++;
                if (got.has_address === 1'b1) addrs_claimed++;
                if (claims_q.size() == 0) begin
                    report_mismatch($sformatf("result with nothing expected: %p", got));
                end else begin
                    want = claims_q.pop_front();
                    if (got.status !== want.status)
                        report_mismatch($sformatf("result %0d status got %0d expected %0d",
                                                  results_seen, got.status, want.status));
                    if (got.has_address !== want.has_address)
                        report_mismatch($sformatf("result %0d has_address got %0d expected %0d",
                                                  results_seen, got.has_address,
                                                  want.has_address));
                    if (got.host_address !== want.host_address)
                        report_mismatch($sformatf("result %0d host_address got %0d expected %0d",
                                                  results_seen, got.host_address,
                                                  want.host_address));
                    if (got.span !== want.span)
                        report_mismatch($sformatf("result %0d span got %0d expected %0d",
                                                  results_seen, got.span, want.span));
                    if (got.last !== want.last)
                        report_mismatch($sformatf("result %0d last got %0d expected %0d",
                                                  results_seen, got.last, want.last));
                end
            end
            // Watchdog on cycles with no transfer on either side
            if (in_took || (o_out_valid && i_out_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Stimulus, reset and end of run
    initial begin
        int k;
        int roll;
        int total;
        int blocks;
        int bnum;
        int count;
        int lim;
        int free_sum;
        int i;

        for (i = 0; i < POOL_SIZE; i++) pool_used[i] = 1'b0;
        for (i = 0; i < BLOCK_LIMIT; i++) begin
            pool_free[i] = 0;
            gen_free[i]  = 0;
        end

        // Directed: refusals before setup, bad counts, size extremes, exhaustion
        queue_request(abpa_pkg::REQ_ALLOC, $urandom_range(0, 511), $urandom_range(0, 127), 1, 1);
        queue_request(abpa_pkg::REQ_PARTITION, 16, 0, $urandom_range(0, 127),
                      $urandom_range(0, 127));
        queue_request(abpa_pkg::REQ_PARTITION, 16, 65, $urandom_range(0, 127),
                      $urandom_range(0, 127));
        queue_request(abpa_pkg::REQ_PARTITION, 511, 127, $urandom_range(0, 127),
                      $urandom_range(0, 127));
        queue_request(abpa_pkg::REQ_PARTITION, 0, 1, $urandom_range(0, 127),
                      $urandom_range(0, 127));
        queue_request(abpa_pkg::REQ_ALLOC, $urandom_range(0, 511), $urandom_range(0, 127), 1, 1);
        queue_request(abpa_pkg::REQ_ALLOC, $urandom_range(0, 511), $urandom_range(0, 127), 1, 1);
        queue_request(abpa_pkg::REQ_ALLOC, $urandom_range(0, 511), $urandom_range(0, 127), 1, 0);
        queue_request(abpa_pkg::REQ_PARTITION, 511, 1, $urandom_range(0, 127),
                      $urandom_range(0, 127));
        queue_request(abpa_pkg::REQ_ALLOC, $urandom_range(0, 511), $urandom_range(0, 127), 1, 64);
        queue_request(abpa_pkg::REQ_ALLOC, $urandom_range(0, 511), $urandom_range(0, 127), 1, 65);
        queue_request(abpa_pkg::REQ_ALLOC, $urandom_range(0, 511), $urandom_range(0, 127), 1, 127);
        queue_request(abpa_pkg::REQ_ALLOC, $urandom_range(0, 511), $urandom_range(0, 127), 2, 1);
        queue_request(abpa_pkg::REQ_ALLOC, $urandom_range(0, 511), $urandom_range(0, 127), 0, 1);
        queue_request(abpa_pkg::REQ_PARTITION, 256, 64, $urandom_range(0, 127),
                      $urandom_range(0, 127));
        queue_request(abpa_pkg::REQ_ALLOC, $urandom_range(0, 511), $urandom_range(0, 127), 64, 4);
        queue_request(abpa_pkg::REQ_ALLOC, $urandom_range(0, 511), $urandom_range(0, 127), 64, 0);
        queue_request(abpa_pkg::REQ_PARTITION, 100, 3, $urandom_range(0, 127),
                      $urandom_range(0, 127));
        queue_request(abpa_pkg::REQ_ALLOC, $urandom_range(0, 511), $urandom_range(0, 127), 3, 42);
        queue_request(abpa_pkg::REQ_PARTITION, 257, 64, $urandom_range(0, 127),
                      $urandom_range(0, 127));
        queue_request(abpa_pkg::REQ_PARTITION, 5, 64, $urandom_range(0, 127),
                      $urandom_range(0, 127));
        queue_request(abpa_pkg::REQ_ALLOC, $urandom_range(0, 511), $urandom_range(0, 127), 64, 1);
        queue_request(abpa_pkg::REQ_ALLOC, $urandom_range(0, 511), $urandom_range(0, 127), 65, 1);
        queue_request(abpa_pkg::REQ_ALLOC, $urandom_range(0, 511), $urandom_range(0, 127), 127, 0);

        // Random: mostly valid setups and allocations that fit, some noise
        for (k = 0; k < RANDOM_ITEMS; k++) begin
            free_sum = 0;
            for (i = 0; i < gen_blocks; i++) free_sum += gen_free[i];
            total  = $urandom_range(0, 511);
            blocks = $urandom_range(0, 127);
            bnum   = $urandom_range(0, 127);
            count  = $urandom_range(0, 127);
            roll   = $urandom_range(0, 99);
            if (gen_blocks == 0 || roll < 10 || (free_sum == 0 && roll < 60)) begin
                roll = $urandom_range(0, 99);
                if (roll < 40) total = $urandom_range(0, 16);
                else if (roll < 80) total = $urandom_range(0, 256);
                roll = $urandom_range(0, 99);
                if (roll < 45) blocks = $urandom_range(1, 8);
                else if (roll < 85) blocks = $urandom_range(1, BLOCK_LIMIT);
                else if (roll < 92) blocks = 0;
                else blocks = $urandom_range(BLOCK_LIMIT + 1, 127);
                queue_request(abpa_pkg::REQ_PARTITION, total, blocks, bnum, count);
            end else if (roll < 88) begin
                bnum = $urandom_range(1, gen_blocks);
                lim  = (gen_free[bnum-1] < abpa_pkg::MAX_RESULTS) ? gen_free[bnum-1]
                                                                  : abpa_pkg::MAX_RESULTS;
                roll = $urandom_range(0, 99);
                if (roll < 60) count = $urandom_range(0, (lim < 6) ? lim : 6);
                else if (roll < 95) count = $urandom_range(0, lim);
                else count = gen_free[bnum-1] + $urandom_range(1, 4);
                if (count > 127) count = 127;
                queue_request(abpa_pkg::REQ_ALLOC, total, blocks, bnum, count);
            end else begin
                queue_request(abpa_pkg::REQ_ALLOC, total, blocks, bnum, count);
            end
        end

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every request to go in and every result to come out
        while (pending_q.size() > 0 || i_in_valid) @(posedge i_clk);
        while (claims_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (claims_q.size() > 0)
            report_mismatch($sformatf("%0d results never arrived", claims_q.size()));

        $display("covered %0d setups, %0d allocations, %0d addresses claimed, %0d refusals",
                 setups_seen, allocs_seen, addrs_claimed, refusals);
        $display("checked %0d results, long receiver hold-off %0s, %0d mismatches",
                 results_seen, pressure_done ? "applied" : "not reached", fail_count);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[address_block_pool_allocator.f]
hw/rtl/abpa_pkg.sv
hw/rtl/abpa_div.sv
hw/rtl/abpa_ctrl.sv
hw/rtl/abpa_dp.sv
hw/rtl/address_block_pool_allocator.sv
dv/address_block_pool_allocator_test.sv
